// File: hdl/sd_card_spi_host_engine_unit_defines.svh
// Assertion macros for the SD SPI host engine
`ifndef SD_CARD_SPI_HOST_ENGINE_UNIT_DEFINES_SVH
`define SD_CARD_SPI_HOST_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SDSPI_ASSERT(label, clk_s, rst_n, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error("assertion failed");
`define SDSPI_ASSERT_IMPL(label, clk_s, rst_n, pre, post) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`else
`define SDSPI_ASSERT(label, clk_s, rst_n, prop)
`define SDSPI_ASSERT_IMPL(label, clk_s, rst_n, pre, post)
`endif
`endif

// File: hdl/sdspi_pkg.sv
`default_nettype none
package sdspi_pkg;
	localparam int BLOCK_BYTES = 512;

	typedef enum logic [18:0] {
		PH_IDLE      = 19'h00001,
		PH_POWERUP   = 19'h00002,
		PH_DESEL     = 19'h00004,
		PH_READY     = 19'h00008,
		PH_SELFAIL   = 19'h00010,
		PH_FRAME     = 19'h00020,
		PH_STUFF     = 19'h00040,
		PH_R1        = 19'h00080,
		PH_TRAIL     = 19'h00100,
		PH_TOKEN     = 19'h00200,
		PH_RDATA     = 19'h00400,
		PH_RCRC      = 19'h00800,
		PH_WREADY    = 19'h01000,
		PH_WTOKEN    = 19'h02000,
		PH_WDATA     = 19'h04000,
		PH_WCRC      = 19'h08000,
		PH_WRESP     = 19'h10000,
		PH_STOPREADY = 19'h20000,
		PH_STOPTOK   = 19'h40000
	} phase_t;

	localparam logic [1:0] OP_XCHG = 2'd0;
	localparam logic [1:0] OP_INIT = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_READY_TO = 3'd1;
	localparam logic [2:0] ST_BAD_RESP = 3'd2;
	localparam logic [2:0] ST_TOKEN_TO = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;
	localparam logic [2:0] ST_INIT_FAIL = 3'd5;

	localparam logic [2:0] CT_NONE = 3'd0;
	localparam logic [2:0] CT_MMC = 3'd1;
	localparam logic [2:0] CT_SD1 = 3'd2;
	localparam logic [2:0] CT_SD2 = 3'd3;
	localparam logic [2:0] CT_SDHC = 3'd4;
	localparam logic [2:0] CT_ERR = 3'd5;

	localparam logic [5:0] CMD0 = 6'd0;
	localparam logic [5:0] CMD1 = 6'd1;
	localparam logic [5:0] CMD8 = 6'd8;
	localparam logic [5:0] CMD12 = 6'd12;
	localparam logic [5:0] CMD16 = 6'd16;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD18 = 6'd18;
	localparam logic [5:0] CMD23 = 6'd23;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD25 = 6'd25;
	localparam logic [5:0] CMD41 = 6'd41;
	localparam logic [5:0] CMD55 = 6'd55;
	localparam logic [5:0] CMD58 = 6'd58;

	localparam logic [2:0] REG_READY = 3'd0;
	localparam logic [2:0] REG_TOKEN = 3'd1;
	localparam logic [2:0] REG_RESP = 3'd2;
	localparam logic [2:0] REG_OPCOND = 3'd3;
	localparam logic [2:0] REG_RESET = 3'd4;
	localparam logic [2:0] REG_PWRUP = 3'd5;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       chip_select_n;
		logic       fast_clock;
		logic       read_valid;
		logic [7:0] read_data;
		logic       write_data_taken;
		logic       busy_res;
		logic       done_res;
		logic [2:0] status;
		logic [2:0] card_type;
	} result_t;
endpackage
`default_nettype wire

// File: hdl/sd_card_spi_host_engine_unit.sv
// SPI-mode SD host engine. Each input transfer is one SPI byte exchange:
// it carries the card's reply to the previous byte, and the result transfer
// gives the next byte to send, chip select and clock speed. One item is
// taken per clock; the state update is a single combinational step between
// the input and the output register, so the rate is one item per cycle
// unless the output side stalls. Limits are set through the APB port.
`default_nettype none
`include "sd_card_spi_host_engine_unit_defines.svh"
module sd_card_spi_host_engine_unit import sdspi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] sector_address,
	input  wire logic [7:0]  block_count,
	input  wire logic [7:0]  card_byte,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  send_byte,
	output logic             chip_select_n,
	output logic             fast_clock,
	output logic             read_valid,
	output logic      [7:0]  read_data,
	output logic             write_data_taken,
	output logic             busy_res,
	output logic             done_res,
	output logic      [2:0]  status,
	output logic      [2:0]  card_type
);
	logic [23:0] ready_lim_q;
	logic [15:0] token_lim_q;
	logic [7:0]  resp_lim_q;
	logic [15:0] opc_lim_q;
	logic [7:0]  reset_lim_q;
	logic [7:0]  pwr_q;

	phase_t      phase_q;
	logic [47:0] frame_q;
	logic [9:0]  bcnt_q;
	logic [7:0]  blocks_q;
	logic [23:0] poll_q;
	logic [15:0] retry_q;
	logic [31:0] reply_q;
	logic [2:0]  ctype_q;
	logic        init_q;

	logic        in_acc;
	logic        res_full_q;
	result_t     res_q;

	assign pready = 1'b1;
	wire cfg_wr = psel && penable && pwrite;
	wire [2:0] cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_lim_q <= 24'hFFFFFF;
			token_lim_q <= 16'hFFFF;
			resp_lim_q <= 8'd31;
			opc_lim_q <= 16'd65534;
			reset_lim_q <= 8'd20;
			pwr_q <= 8'd10;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_READY: ready_lim_q <= pwdata[23:0];
				REG_TOKEN: token_lim_q <= pwdata[15:0];
				REG_RESP: resp_lim_q <= pwdata[7:0];
				REG_OPCOND: opc_lim_q <= pwdata[15:0];
				REG_RESET: reset_lim_q <= pwdata[7:0];
				REG_PWRUP: pwr_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_READY: prdata = {8'd0, ready_lim_q};
			REG_TOKEN: prdata = {16'd0, token_lim_q};
			REG_RESP: prdata = {24'd0, resp_lim_q};
			REG_OPCOND: prdata = {16'd0, opc_lim_q};
			REG_RESET: prdata = {24'd0, reset_lim_q};
			REG_PWRUP: prdata = {24'd0, pwr_q};
			default: prdata = 32'd0;
		endcase
	end

	// output register with one stage: input waits only while a result is held and stalled
	assign in_stall = res_full_q && out_stall;
	assign in_acc = in_valid && !in_stall;
	assign out_valid = res_full_q;

	// next-state logic
	phase_t      n_phase;
	logic [47:0] n_frame;
	logic [9:0]  n_bcnt;
	logic [7:0]  n_blocks;
	logic [23:0] n_poll;
	logic [15:0] n_retry;
	logic [31:0] n_reply;
	logic [2:0]  n_ctype;
	logic        n_init;
	logic [7:0]  o_send;
	logic        o_cs, o_rv, o_take, o_done, o_slow;
	logic [7:0]  o_rd;
	logic [2:0]  o_status;

	logic [5:0]  fcmd;
	logic [31:0] farg;
	logic [23:0] poll_inc;
	logic [9:0]  bcnt_inc;
	logic [7:0]  blk_dec;
	logic [31:0] xaddr;
	logic [2:0]  wb_st;

	assign fcmd = frame_q[45:40];
	assign farg = frame_q[39:8];
	assign poll_inc = poll_q + 24'd1;
	assign bcnt_inc = bcnt_q + 10'd1;
	assign blk_dec = blocks_q - 8'd1;
	assign xaddr = (ctype_q == CT_SDHC) ? sector_address : {sector_address[22:0], 9'd0};

	always_comb begin
		n_phase = phase_q; n_frame = frame_q; n_bcnt = bcnt_q; n_blocks = blocks_q;
		n_poll = poll_q; n_retry = retry_q; n_reply = reply_q; n_ctype = ctype_q;
		n_init = init_q;
		o_send = 8'hFF; o_cs = 1'b1; o_rv = 1'b0; o_rd = 8'd0; o_take = 1'b0;
		o_done = 1'b0; o_status = ST_OK;
		o_slow = (phase_q != PH_IDLE) && !init_q;
		wb_st = ST_OK;

		case (phase_q)
			PH_IDLE: begin
				n_phase = PH_IDLE;
				if (opcode == OP_INIT) begin
					if (init_q) begin
						o_done = 1'b1;
					end else begin
						o_slow = 1'b1;
						n_ctype = CT_NONE;
						n_reply = '0;
						if (8'd0 < pwr_q) begin
							n_bcnt = 10'd1;
							n_phase = PH_POWERUP;
						end else begin
							n_bcnt = '0;
							n_retry = '0;
							n_frame = {8'h40, 32'd0, 8'h95};
							n_phase = PH_DESEL;
						end
					end
				end else if (opcode == OP_READ || opcode == OP_WRITE) begin
					if (!init_q) begin
						o_done = 1'b1; o_status = ST_INIT_FAIL;
					end else if (block_count == 8'd0) begin
						o_done = 1'b1;
					end else begin
						n_blocks = block_count;
						n_reply = '0;
						n_phase = PH_DESEL;
						if (opcode == OP_READ)
							n_frame = {2'b01, (block_count == 8'd1) ? CMD17 : CMD18,
								xaddr, 8'h01};
						else if (block_count == 8'd1)
							n_frame = {2'b01, CMD24, xaddr, 8'h01};
						else if (ctype_q != CT_MMC) begin
							n_reply = xaddr;
							n_frame = {2'b01, CMD55, 32'd0, 8'h01};
						end else
							n_frame = {2'b01, CMD25, xaddr, 8'h01};
					end
				end
			end
			PH_POWERUP: begin
				if ({2'd0, pwr_q} > bcnt_q) begin
					n_bcnt = bcnt_inc;
				end else begin
					n_retry = '0;
					n_frame = {8'h40, 32'd0, 8'h95};
					n_phase = PH_DESEL;
				end
			end
			PH_DESEL: begin
				n_poll = '0; o_cs = 1'b0; n_phase = PH_READY;
			end
			PH_READY: begin
				if (card_byte == 8'hFF) begin
					n_bcnt = '0; o_send = frame_q[47:40]; o_cs = 1'b0; n_phase = PH_FRAME;
				end else begin
					n_poll = poll_inc;
					if (poll_inc >= ready_lim_q) n_phase = PH_SELFAIL;
					else o_cs = 1'b0;
				end
			end
			PH_FRAME: begin
				n_bcnt = bcnt_inc;
				o_cs = 1'b0;
				case (bcnt_inc[2:0])
					3'd1: o_send = frame_q[39:32];
					3'd2: o_send = frame_q[31:24];
					3'd3: o_send = frame_q[23:16];
					3'd4: o_send = frame_q[15:8];
					3'd5: o_send = frame_q[7:0];
					default: o_send = 8'hFF;
				endcase
				if (bcnt_inc >= 10'd6) begin
					if (fcmd == CMD12) n_phase = PH_STUFF;
					else begin n_poll = '0; n_phase = PH_R1; end
				end
			end
			PH_STUFF: begin
				n_poll = '0; o_cs = 1'b0; n_phase = PH_R1;
			end
			PH_TRAIL: begin
				n_reply = {reply_q[23:0], card_byte};
				n_bcnt = bcnt_inc;
				if (bcnt_inc < 10'd4) begin
					o_cs = 1'b0;
				end else if (fcmd == CMD8) begin
					if (n_reply[15:0] == 16'h01AA) begin
						n_retry = '0;
						n_frame = {2'b01, CMD55, 32'd0, 8'h01};
						n_phase = PH_DESEL;
					end else begin
						n_ctype = CT_NONE; n_init = 1'b0; o_done = 1'b1;
						o_status = ST_INIT_FAIL; n_phase = PH_IDLE;
					end
				end else begin
					n_ctype = n_reply[30] ? CT_SDHC : CT_SD2;
					n_init = 1'b1; o_done = 1'b1; n_phase = PH_IDLE;
				end
			end
			PH_TOKEN: begin
				o_cs = 1'b0;
				if (card_byte == 8'hFE) begin
					n_bcnt = '0; n_phase = PH_RDATA;
				end else begin
					n_poll = poll_inc;
					if ({8'd0, token_lim_q} <= poll_inc) begin
						if (fcmd == CMD17) begin
							o_cs = 1'b1; o_done = 1'b1; o_status = ST_TOKEN_TO;
							n_phase = PH_IDLE;
						end else begin
							o_cs = 1'b1; n_reply = {29'd0, ST_TOKEN_TO};
							n_frame = {2'b01, CMD12, 32'd0, 8'h01}; n_phase = PH_DESEL;
						end
					end
				end
			end
			PH_RDATA: begin
				o_cs = 1'b0; o_rv = 1'b1; o_rd = card_byte;
				if (bcnt_inc < 10'(BLOCK_BYTES) && bcnt_q != 10'(BLOCK_BYTES - 1))
					n_bcnt = bcnt_inc;
				else begin n_bcnt = '0; n_phase = PH_RCRC; end
			end
			PH_RCRC: begin
				n_bcnt = bcnt_inc;
				if (bcnt_inc < 10'd2) o_cs = 1'b0;
				else if (fcmd == CMD17) begin
					o_done = 1'b1; n_phase = PH_IDLE;
				end else begin
					n_blocks = blk_dec;
					if (blk_dec != 8'd0) begin
						n_poll = '0; o_cs = 1'b0; n_phase = PH_TOKEN;
					end else begin
						n_reply = '0;
						n_frame = {2'b01, CMD12, 32'd0, 8'h01}; n_phase = PH_DESEL;
					end
				end
			end
			PH_WTOKEN: begin
				o_send = write_data; o_cs = 1'b0; o_take = 1'b1; n_bcnt = 10'd1;
				n_phase = PH_WDATA;
			end
			PH_WDATA: begin
				o_cs = 1'b0;
				if (bcnt_q != 10'(BLOCK_BYTES) && bcnt_q < 10'(BLOCK_BYTES - 1) + 10'd1) begin
					o_send = write_data; o_take = 1'b1; n_bcnt = bcnt_inc;
				end else begin
					n_bcnt = '0; n_phase = PH_WCRC;
				end
			end
			PH_WCRC: begin
				o_cs = 1'b0; n_bcnt = bcnt_inc;
				n_phase = (bcnt_inc < 10'd2) ? PH_WCRC : PH_WRESP;
			end
			PH_STOPREADY: begin
				if (card_byte == 8'hFF) begin
					o_send = 8'hFD; o_cs = 1'b0; n_phase = PH_STOPTOK;
				end else begin
					n_poll = poll_inc;
					if (poll_inc >= ready_lim_q) begin
						o_done = 1'b1; o_status = ST_READY_TO; n_phase = PH_IDLE;
					end else o_cs = 1'b0;
				end
			end
			PH_STOPTOK: begin
				o_done = 1'b1; o_status = reply_q[2:0]; n_phase = PH_IDLE;
			end
			PH_SELFAIL, PH_R1, PH_WREADY, PH_WRESP: ;
			default: n_phase = PH_IDLE;
		endcase

		// write block end (ready timeout or data response)
		if ((phase_q == PH_WREADY && card_byte != 8'hFF && poll_inc >= ready_lim_q)
			|| phase_q == PH_WRESP) begin
			if (phase_q == PH_WRESP)
				wb_st = (card_byte[4:0] == 5'h05) ? ST_OK : ST_REJECT;
			else
				wb_st = ST_READY_TO;
			if (phase_q == PH_WREADY) n_poll = poll_inc;
			if (fcmd == CMD24) begin
				o_done = 1'b1; o_status = wb_st; o_cs = 1'b1; n_phase = PH_IDLE;
			end else begin
				n_blocks = blk_dec;
				n_poll = '0; o_cs = 1'b0;
				if (wb_st == ST_OK && blk_dec != 8'd0) n_phase = PH_WREADY;
				else begin n_reply = {29'd0, wb_st}; n_phase = PH_STOPREADY; end
			end
		end else if (phase_q == PH_WREADY) begin
			o_cs = 1'b0;
			if (card_byte == 8'hFF) begin
				o_send = (fcmd == CMD24) ? 8'hFE : 8'hFC; n_phase = PH_WTOKEN;
			end else n_poll = poll_inc;
		end

		// R1 polling and command completion, also after a select failure
		if (phase_q == PH_R1 && card_byte[7] && poll_q < {16'd0, resp_lim_q}) begin
			n_poll = poll_inc; o_cs = 1'b0;
		end else if (phase_q == PH_R1 || phase_q == PH_SELFAIL) begin
			logic [7:0] r1;
			logic       rfail;
			r1 = (phase_q == PH_SELFAIL) ? 8'hFF : card_byte;
			rfail = (phase_q == PH_SELFAIL);
			o_cs = 1'b1; o_send = 8'hFF;
			n_phase = PH_DESEL;
			case (fcmd)
				CMD0: begin
					if (r1 == 8'h01) n_frame = {2'b01, CMD8, 32'h000001AA, 8'h87};
					else if (retry_q < {8'd0, reset_lim_q}) begin
						n_retry = retry_q + 16'd1; n_frame = {8'h40, 32'd0, 8'h95};
					end else begin
						n_ctype = CT_NONE; n_init = 1'b0; o_done = 1'b1;
						o_status = ST_INIT_FAIL; n_phase = PH_IDLE;
					end
				end
				CMD8: begin
					n_reply = '0;
					if (r1 == 8'h01) begin
						n_bcnt = '0; o_cs = 1'b0; n_phase = PH_TRAIL;
					end else n_frame = {2'b01, CMD55, 32'd0, 8'h01};
				end
				CMD55: begin
					if (init_q) n_frame = {2'b01, CMD23, 24'd0, blocks_q, 8'h01};
					else n_frame = {2'b01, CMD41,
						(reply_q[15:0] == 16'h01AA) ? 32'h40000000 : 32'd0, 8'h01};
				end
				CMD41, CMD1: begin
					if (fcmd == CMD41 && farg != 32'd0) begin
						if (r1 == 8'd0) n_frame = {2'b01, CMD58, 32'd0, 8'h01};
						else if (retry_q < opc_lim_q) begin
							n_retry = retry_q + 16'd1;
							n_frame = {2'b01, CMD55, 32'd0, 8'h01};
						end else begin
							n_ctype = CT_NONE; n_init = 1'b0; o_done = 1'b1;
							o_status = ST_INIT_FAIL; n_phase = PH_IDLE;
						end
					end else if (fcmd == CMD41 && ctype_q == CT_NONE) begin
						n_retry = '0;
						if (r1 <= 8'd1) begin
							n_ctype = CT_SD1; n_frame = {2'b01, CMD55, 32'd0, 8'h01};
						end else begin
							n_ctype = CT_MMC; n_frame = {2'b01, CMD1, 32'd0, 8'h01};
						end
					end else begin
						if (r1 == 8'd0)
							n_frame = {2'b01, CMD16, 32'(BLOCK_BYTES), 8'h01};
						else if (retry_q < opc_lim_q) begin
							n_retry = retry_q + 16'd1;
							n_frame = {2'b01, (fcmd == CMD1) ? CMD1 : CMD55, 32'd0, 8'h01};
						end else begin
							n_ctype = CT_ERR; n_init = 1'b0; o_done = 1'b1;
							o_status = ST_INIT_FAIL; n_phase = PH_IDLE;
						end
					end
				end
				CMD16: begin
					o_done = 1'b1; n_phase = PH_IDLE;
					if (r1 == 8'd0) n_init = 1'b1;
					else begin n_ctype = CT_ERR; n_init = 1'b0; o_status = ST_INIT_FAIL; end
				end
				CMD58: begin
					if (r1 == 8'd0) begin
						n_bcnt = '0; o_cs = 1'b0; n_phase = PH_TRAIL;
					end else begin
						n_ctype = CT_NONE; n_init = 1'b0; o_done = 1'b1;
						o_status = ST_INIT_FAIL; n_phase = PH_IDLE;
					end
				end
				CMD17, CMD18, CMD24, CMD25: begin
					if (rfail) begin
						o_done = 1'b1; o_status = ST_READY_TO; n_phase = PH_IDLE;
					end else if (r1 != 8'd0) begin
						o_done = 1'b1; o_status = ST_BAD_RESP; n_phase = PH_IDLE;
					end else begin
						n_poll = '0; o_cs = 1'b0;
						n_phase = (fcmd == CMD17 || fcmd == CMD18) ? PH_TOKEN : PH_WREADY;
					end
				end
				CMD23: n_frame = {2'b01, CMD25, reply_q, 8'h01};
				CMD12: begin
					o_done = 1'b1; o_status = reply_q[2:0]; n_phase = PH_IDLE;
				end
				default: begin
					o_done = 1'b1; o_status = ST_BAD_RESP; n_phase = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			frame_q <= '0;
			bcnt_q <= '0;
			blocks_q <= '0;
			poll_q <= '0;
			retry_q <= '0;
			reply_q <= '0;
			ctype_q <= CT_NONE;
			init_q <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q <= n_phase;
				frame_q <= n_frame;
				bcnt_q <= n_bcnt;
				blocks_q <= n_blocks;
				poll_q <= n_poll;
				retry_q <= n_retry;
				reply_q <= n_reply;
				ctype_q <= n_ctype;
				init_q <= n_init;
				res_full_q <= 1'b1;
			end else if (!out_stall) begin
				res_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q.send_byte <= o_send;
			res_q.chip_select_n <= o_cs;
			res_q.fast_clock <= !o_slow;
			res_q.read_valid <= o_rv;
			res_q.read_data <= o_rd;
			res_q.write_data_taken <= o_take;
			res_q.busy_res <= (n_phase != PH_IDLE);
			res_q.done_res <= o_done;
			res_q.status <= o_status;
			res_q.card_type <= n_ctype;
		end
	end

	assign send_byte = res_q.send_byte;
	assign chip_select_n = res_q.chip_select_n;
	assign fast_clock = res_q.fast_clock;
	assign read_valid = res_q.read_valid;
	assign read_data = res_q.read_data;
	assign write_data_taken = res_q.write_data_taken;
	assign busy_res = res_q.busy_res;
	assign done_res = res_q.done_res;
	assign status = res_q.status;
	assign card_type = res_q.card_type;

	`SDSPI_ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid && done_res, !busy_res && chip_select_n)
	`SDSPI_ASSERT_IMPL(a_take_sel, clk, arst_n, out_valid && write_data_taken, !chip_select_n)
	`SDSPI_ASSERT_IMPL(a_rd_zero, clk, arst_n, out_valid && !read_valid, read_data == 8'd0)
	`SDSPI_ASSERT_IMPL(a_status_done, clk, arst_n, out_valid && !done_res, status == ST_OK)
endmodule
`default_nettype wire

// File: tb/sd_card_spi_host_engine_unit_tb.sv
`default_nettype none
module sd_card_spi_host_engine_unit_tb;
	import sdspi_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_XCHG;
	logic [31:0] sector_address = '0;
	logic [7:0]  block_count = 8'd1;
	logic [7:0]  card_byte = 8'hFF;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  send_byte;
	logic        chip_select_n;
	logic        fast_clock;
	logic        read_valid;
	logic [7:0]  read_data;
	logic        write_data_taken;
	logic        busy_res;
	logic        done_res;
	logic [2:0]  status;
	logic [2:0]  card_type;

	sd_card_spi_host_engine_unit uut (.*);

	always #5 clk = ~clk;

	// engine model state
	phase_t      ph = PH_IDLE;
	logic [47:0] frame = '0;
	logic [9:0]  bcnt = '0;
	logic [7:0]  blk = '0;
	logic [23:0] polls = '0;
	logic [15:0] tries = '0;
	logic [31:0] reply = '0;
	logic [2:0]  ctype = CT_NONE;
	bit          inited = 1'b0;
	logic [23:0] lim_ready = 24'hFFFFFF;
	logic [15:0] lim_token = 16'hFFFF;
	logic [7:0]  lim_resp = 8'd31;
	logic [15:0] lim_opc = 16'd65534;
	logic [7:0]  lim_reset = 8'd20;
	logic [7:0]  n_pwrup = 8'd10;

	logic [7:0]  nx_send, nx_rd;
	logic        nx_cs, nx_rv, nx_take, nx_done;
	logic [2:0]  nx_stat;

	result_t     byte_q[$];
	int          errors = 0;
	int          acc_count = 0;
	int          snd_pct = 0, rcv_pct = 0;
	bit          tbl_chk = 1'b0;
	logic [7:0]  tbl_send;
	logic        tbl_cs, tbl_done;
	logic [2:0]  tbl_st;

	// emulated card
	int          prof = 0;
	int          flaw = 0;
	int          idle_left = 0;
	int          flaw_mode = 0;

	function automatic void emit_b(logic [7:0] b, logic cs, phase_t p);
		nx_send = b;
		nx_cs = cs;
		ph = p;
	endfunction

	function automatic void finish_op(logic [2:0] st);
		emit_b(8'hFF, 1'b1, PH_IDLE);
		nx_done = 1'b1;
		nx_stat = st;
	endfunction

	function automatic void issue(logic [5:0] c, logic [31:0] a, logic [7:0] crc);
		frame = {2'b01, c, a, crc};
		emit_b(8'hFF, 1'b1, PH_DESEL);
	endfunction

	function automatic void issue_std(logic [5:0] c, logic [31:0] a);
		issue(c, a, 8'h01);
	endfunction

	function automatic void init_fail(logic [2:0] t);
		ctype = t;
		inited = 1'b0;
		finish_op(ST_INIT_FAIL);
	endfunction

	function automatic void init_ok();
		inited = 1'b1;
		finish_op(ST_OK);
	endfunction

	function automatic void poll_begin(phase_t p);
		polls = '0;
		emit_b(8'hFF, 1'b0, p);
	endfunction

	function automatic void op_retry(logic [5:0] c, logic [2:0] t);
		if (tries < lim_opc) begin
			tries++;
			issue_std(c, '0);
		end else init_fail(t);
	endfunction

	function automatic void cmd_done(logic [7:0] r1, bit rfail);
		logic [5:0] c;
		c = frame[45:40];
		case (c)
			CMD0: begin
				if (r1 == 8'h01) issue(CMD8, 32'h000001AA, 8'h87);
				else if (tries < lim_reset) begin
					tries++;
					issue(CMD0, '0, 8'h95);
				end else init_fail(CT_NONE);
			end
			CMD8: begin
				reply = '0;
				if (r1 == 8'h01) begin
					bcnt = '0;
					emit_b(8'hFF, 1'b0, PH_TRAIL);
				end else issue_std(CMD55, '0);
			end
			CMD55: begin
				if (inited) issue_std(CMD23, {24'd0, blk});
				else issue_std(CMD41, (reply[15:0] == 16'h01AA) ? 32'h40000000 : 32'h0);
			end
			CMD41: begin
				if (frame[39:8] != 0) begin
					if (r1 == 0) issue_std(CMD58, '0);
					else op_retry(CMD55, CT_NONE);
				end else if (ctype == CT_NONE) begin
					tries = '0;
					if (r1 <= 1) begin
						ctype = CT_SD1;
						issue_std(CMD55, '0);
					end else begin
						ctype = CT_MMC;
						issue_std(CMD1, '0);
					end
				end else begin
					if (r1 == 0) issue_std(CMD16, BLOCK_BYTES);
					else op_retry(CMD55, CT_ERR);
				end
			end
			CMD1: begin
				if (r1 == 0) issue_std(CMD16, BLOCK_BYTES);
				else op_retry(CMD1, CT_ERR);
			end
			CMD16: begin
				if (r1 == 0) init_ok();
				else init_fail(CT_ERR);
			end
			CMD58: begin
				if (r1 == 0) begin
					bcnt = '0;
					emit_b(8'hFF, 1'b0, PH_TRAIL);
				end else init_fail(CT_NONE);
			end
			CMD17, CMD18, CMD24, CMD25: begin
				if (rfail) finish_op(ST_READY_TO);
				else if (r1 != 0) finish_op(ST_BAD_RESP);
				else if (c == CMD17 || c == CMD18) poll_begin(PH_TOKEN);
				else poll_begin(PH_WREADY);
			end
			CMD23: issue_std(CMD25, reply);
			CMD12: finish_op(reply[2:0]);
			default: finish_op(ST_BAD_RESP);
		endcase
	endfunction

	function automatic void powerup_next();
		if (bcnt < n_pwrup) begin
			bcnt++;
			emit_b(8'hFF, 1'b1, PH_POWERUP);
		end else begin
			tries = '0;
			issue(CMD0, '0, 8'h95);
		end
	endfunction

	function automatic void wblock_end(logic [2:0] st);
		if (frame[45:40] == CMD24) begin
			finish_op(st);
			return;
		end
		blk--;
		if (st == ST_OK && blk != 0) poll_begin(PH_WREADY);
		else begin
			reply = st;
			poll_begin(PH_STOPREADY);
		end
	endfunction

	function automatic void read_stop(logic [2:0] st);
		if (frame[45:40] == CMD17) begin
			finish_op(st);
			return;
		end
		reply = st;
		issue_std(CMD12, '0);
	endfunction

	function automatic result_t exchange_byte(logic [1:0] op, logic [31:0] sec,
			logic [7:0] cnt, logic [7:0] cb, logic [7:0] wd);
		result_t r;
		bit slow;
		logic [31:0] addr;
		int k;
		slow = (ph != PH_IDLE) && !inited;
		nx_send = 8'hFF; nx_cs = 1'b1; nx_rv = 1'b0; nx_rd = '0;
		nx_take = 1'b0; nx_done = 1'b0; nx_stat = ST_OK;
		case (ph)
			PH_IDLE: begin
				if (op == OP_INIT) begin
					if (inited) finish_op(ST_OK);
					else begin
						slow = 1'b1;
						ctype = CT_NONE;
						reply = '0;
						bcnt = '0;
						powerup_next();
					end
				end else if (op == OP_READ || op == OP_WRITE) begin
					addr = (ctype == CT_SDHC) ? sec : (sec << 9);
					if (!inited) finish_op(ST_INIT_FAIL);
					else if (cnt == 0) finish_op(ST_OK);
					else begin
						blk = cnt;
						reply = '0;
						if (op == OP_READ) issue_std((cnt == 1) ? CMD17 : CMD18, addr);
						else if (cnt == 1) issue_std(CMD24, addr);
						else if (ctype != CT_MMC) begin
							reply = addr;
							issue_std(CMD55, '0);
						end else issue_std(CMD25, addr);
					end
				end else emit_b(8'hFF, 1'b1, PH_IDLE);
			end
			PH_POWERUP: powerup_next();
			PH_DESEL: poll_begin(PH_READY);
			PH_READY: begin
				if (cb == 8'hFF) begin
					bcnt = '0;
					emit_b(frame[47:40], 1'b0, PH_FRAME);
				end else begin
					polls++;
					if (polls >= lim_ready) emit_b(8'hFF, 1'b1, PH_SELFAIL);
					else emit_b(8'hFF, 1'b0, PH_READY);
				end
			end
			PH_SELFAIL: cmd_done(8'hFF, 1'b1);
			PH_FRAME: begin
				bcnt++;
				k = 5 - int'(bcnt);
				if (bcnt < 6) emit_b(frame[8*k +: 8], 1'b0, PH_FRAME);
				else if (frame[45:40] == CMD12) emit_b(8'hFF, 1'b0, PH_STUFF);
				else poll_begin(PH_R1);
			end
			PH_STUFF: poll_begin(PH_R1);
			PH_R1: begin
				if (cb[7] && polls < lim_resp) begin
					polls++;
					emit_b(8'hFF, 1'b0, PH_R1);
				end else cmd_done(cb, 1'b0);
			end
			PH_TRAIL: begin
				reply = {reply[23:0], cb};
				bcnt++;
				if (bcnt < 4) emit_b(8'hFF, 1'b0, PH_TRAIL);
				else if (frame[45:40] == CMD8) begin
					if (reply[15:0] == 16'h01AA) begin
						tries = '0;
						issue_std(CMD55, '0);
					end else init_fail(CT_NONE);
				end else begin
					ctype = reply[30] ? CT_SDHC : CT_SD2;
					init_ok();
				end
			end
			PH_TOKEN: begin
				if (cb == 8'hFE) begin
					bcnt = '0;
					emit_b(8'hFF, 1'b0, PH_RDATA);
				end else begin
					polls++;
					if (polls >= lim_token) read_stop(ST_TOKEN_TO);
					else emit_b(8'hFF, 1'b0, PH_TOKEN);
				end
			end
			PH_RDATA: begin
				nx_rv = 1'b1;
				nx_rd = cb;
				bcnt++;
				if (bcnt < BLOCK_BYTES) emit_b(8'hFF, 1'b0, PH_RDATA);
				else begin
					bcnt = '0;
					emit_b(8'hFF, 1'b0, PH_RCRC);
				end
			end
			PH_RCRC: begin
				bcnt++;
				if (bcnt < 2) emit_b(8'hFF, 1'b0, PH_RCRC);
				else if (frame[45:40] == CMD17) finish_op(ST_OK);
				else begin
					blk--;
					if (blk != 0) poll_begin(PH_TOKEN);
					else read_stop(ST_OK);
				end
			end
			PH_WREADY: begin
				if (cb == 8'hFF)
					emit_b((frame[45:40] == CMD24) ? 8'hFE : 8'hFC, 1'b0, PH_WTOKEN);
				else begin
					polls++;
					if (polls >= lim_ready) wblock_end(ST_READY_TO);
					else emit_b(8'hFF, 1'b0, PH_WREADY);
				end
			end
			PH_WTOKEN: begin
				emit_b(wd, 1'b0, PH_WDATA);
				nx_take = 1'b1;
				bcnt = 10'd1;
			end
			PH_WDATA: begin
				if (bcnt < BLOCK_BYTES) begin
					emit_b(wd, 1'b0, PH_WDATA);
					nx_take = 1'b1;
					bcnt++;
				end else begin
					bcnt = '0;
					emit_b(8'hFF, 1'b0, PH_WCRC);
				end
			end
			PH_WCRC: begin
				bcnt++;
				emit_b(8'hFF, 1'b0, (bcnt < 2) ? PH_WCRC : PH_WRESP);
			end
			PH_WRESP: wblock_end((cb[4:0] == 5'h05) ? ST_OK : ST_REJECT);
			PH_STOPREADY: begin
				if (cb == 8'hFF) emit_b(8'hFD, 1'b0, PH_STOPTOK);
				else begin
					polls++;
					if (polls >= lim_ready) finish_op(ST_READY_TO);
					else emit_b(8'hFF, 1'b0, PH_STOPREADY);
				end
			end
			PH_STOPTOK: finish_op(reply[2:0]);
			default: emit_b(8'hFF, 1'b1, PH_IDLE);
		endcase
		r.send_byte = nx_send;
		r.chip_select_n = nx_cs;
		r.fast_clock = !slow;
		r.read_valid = nx_rv;
		r.read_data = nx_rd;
		r.write_data_taken = nx_take;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = nx_done;
		r.status = nx_stat;
		r.card_type = ctype;
		return r;
	endfunction

	task automatic report(string fld, int got, int want);
		errors++;
		$display("mismatch %s: got %0h want %0h (transfer %0d)", fld, got, want, acc_count);
	endtask

	always @(posedge clk) begin
		result_t r, w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r = exchange_byte(opcode, sector_address, block_count, card_byte, write_data);
				if (tbl_chk) begin
					r.send_byte = tbl_send;
					r.chip_select_n = tbl_cs;
					r.done_res = tbl_done;
					r.status = tbl_st;
				end
				byte_q.push_back(r);
				acc_count++;
			end
			if (out_valid && !out_stall) begin
				if (byte_q.size() == 0) report("unexpected transfer", 0, 0);
				else begin
					w = byte_q.pop_front();
					if (send_byte !== w.send_byte) report("send_byte", send_byte, w.send_byte);
					if (chip_select_n !== w.chip_select_n)
						report("chip_select_n", chip_select_n, w.chip_select_n);
					if (fast_clock !== w.fast_clock) report("fast_clock", fast_clock, w.fast_clock);
					if (read_valid !== w.read_valid) report("read_valid", read_valid, w.read_valid);
					if (read_data !== w.read_data) report("read_data", read_data, w.read_data);
					if (write_data_taken !== w.write_data_taken)
						report("write_data_taken", write_data_taken, w.write_data_taken);
					if (busy_res !== w.busy_res) report("busy_res", busy_res, w.busy_res);
					if (done_res !== w.done_res) report("done_res", done_res, w.done_res);
					if (status !== w.status) report("status", status, w.status);
					if (card_type !== w.card_type) report("card_type", card_type, w.card_type);
				end
			end
		end
	end

	always @(negedge clk) out_stall = ($urandom_range(99) < rcv_pct);

	task automatic drive_xfer(logic [1:0] op, logic [31:0] sec, logic [7:0] cnt,
			logic [7:0] cb, logic [7:0] wd);
		int seen;
		while ($urandom_range(99) < snd_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		sector_address = sec;
		block_count = cnt;
		card_byte = cb;
		write_data = wd;
		seen = acc_count;
		do @(negedge clk); while (acc_count == seen);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (byte_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_READY: lim_ready = val[23:0];
			REG_TOKEN: lim_token = val[15:0];
			REG_RESP: lim_resp = val[7:0];
			REG_OPCOND: lim_opc = val[15:0];
			REG_RESET: lim_reset = val[7:0];
			default: n_pwrup = val[7:0];
		endcase
	endtask

	task automatic set_limits(logic [23:0] rdy, logic [15:0] tok, logic [7:0] rsp,
			logic [15:0] opc, logic [7:0] rst, logic [7:0] pwr);
		apb_write(REG_READY, rdy);
		apb_write(REG_TOKEN, tok);
		apb_write(REG_RESP, rsp);
		apb_write(REG_OPCOND, opc);
		apb_write(REG_RESET, rst);
		apb_write(REG_PWRUP, pwr);
	endtask

	function automatic logic [7:0] idle_r1();
		if (idle_left > 0) begin
			idle_left--;
			return 8'h01;
		end
		return 8'h00;
	endfunction

	// byte the emulated card returns, given what the engine is waiting for
	function automatic logic [7:0] card_reply();
		logic [5:0] c;
		c = frame[45:40];
		if ($urandom_range(15) == 0) return 8'($urandom);
		case (ph)
			PH_READY, PH_WREADY, PH_STOPREADY:
				return ($urandom_range(7) == 0) ? 8'h00 : 8'hFF;
			PH_TOKEN: return ($urandom_range(3) == 0) ? 8'hFF : 8'hFE;
			PH_WRESP: return {3'($urandom), ($urandom_range(7) == 0) ? 5'h0B : 5'h05};
			PH_RDATA: return 8'($urandom);
			PH_TRAIL: begin
				if (c == CMD8) begin
					case (bcnt)
						0, 1: return 8'h00;
						2: return 8'h01;
						default: return (flaw == 2) ? 8'h55 : 8'hAA;
					endcase
				end
				if (bcnt == 0) return (prof == 0) ? 8'hC0 : 8'h80;
				return 8'hFF;
			end
			PH_R1: begin
				if ($urandom_range(4) == 0) return 8'hFF;
				case (c)
					CMD0: return (flaw == 1) ? 8'h05 : 8'h01;
					CMD8: return (prof <= 1) ? 8'h01 : 8'h05;
					CMD55: return 8'h01;
					CMD41: return (prof == 3) ? 8'h05 : idle_r1();
					CMD1: return idle_r1();
					CMD58: return (flaw == 3) ? 8'h04 : 8'h00;
					CMD16: return (flaw == 4) ? 8'h04 : 8'h00;
					default: return 8'h00;
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_random(int n);
		logic [1:0] op;
		logic [7:0] cnt;
		for (int k = 0; k < n || ph != PH_IDLE; k++) begin
			op = 2'($urandom_range(3));
			cnt = ($urandom_range(3) == 0) ? 8'($urandom_range(2, 3)) : 8'd1;
			if (ph == PH_IDLE) begin
				if (!inited && $urandom_range(4) != 0) op = OP_INIT;
				if (op == OP_INIT && !inited) begin
					prof = $urandom_range(3);
					idle_left = $urandom_range(3);
					case (flaw_mode)
						0: flaw = $urandom_range(1, 4);
						1: flaw = ($urandom_range(1) == 0) ? 0 : $urandom_range(2, 4);
						default: flaw = $urandom_range(4);
					endcase
					if ((flaw == 2 || flaw == 3) && prof >= 2) flaw = 4;
					if (flaw == 4 && prof < 2) flaw = 3;
				end
			end
			drive_xfer(op, $urandom, cnt, card_reply(), 8'($urandom));
		end
	endtask

	typedef struct {
		logic [1:0]  op;
		logic [31:0] sec;
		logic [7:0]  cnt;
		logic [7:0]  cb;
		logic [7:0]  wd;
		bit          chk;
		logic [7:0]  send;
		logic        cs;
		logic        done;
		logic [2:0]  st;
	} row_t;

	row_t dir_rows[$];

	initial begin
		dir_rows.push_back('{OP_XCHG, 32'h0, 8'd1, 8'h00, 8'h00, 1, 8'hFF, 1, 0, ST_OK});
		dir_rows.push_back('{OP_XCHG, 32'hFFFFFFFF, 8'd255, 8'hFF, 8'hFF, 1, 8'hFF, 1, 0, ST_OK});
		dir_rows.push_back('{OP_READ, 32'hFFFFFFFF, 8'd255, 8'hA5, 8'h5A, 1, 8'hFF, 1, 1,
			ST_INIT_FAIL});
		dir_rows.push_back('{OP_WRITE, 32'h0, 8'd1, 8'h5A, 8'hA5, 1, 8'hFF, 1, 1, ST_INIT_FAIL});
		dir_rows.push_back('{OP_READ, 32'h0, 8'd0, 8'h00, 8'h00, 1, 8'hFF, 1, 1, ST_INIT_FAIL});
		dir_rows.push_back('{OP_WRITE, 32'h80000000, 8'd255, 8'hFF, 8'hFF, 1, 8'hFF, 1, 1,
			ST_INIT_FAIL});
		dir_rows.push_back('{OP_INIT, 32'h0, 8'd1, 8'hFF, 8'h00, 1, 8'hFF, 1, 0, ST_OK});
		for (int i = 0; i < 10; i++)
			dir_rows.push_back('{(i % 2) ? OP_WRITE : OP_READ, 32'h12345678, 8'd2,
				(i % 2) ? 8'hAA : 8'h55, (i % 2) ? 8'h55 : 8'hAA, 1, 8'hFF, 1, 0, ST_OK});
		// CMD0 frame, card ready
		dir_rows.push_back('{OP_XCHG, 32'h0, 8'd1, 8'hFF, 8'h00, 0, 0, 0, 0, ST_OK});
		dir_rows.push_back('{OP_XCHG, 32'h0, 8'd1, 8'hFF, 8'h00, 0, 0, 0, 0, ST_OK});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_pct = 19;
		rcv_pct = 46;
		foreach (dir_rows[i]) begin
			tbl_chk = dir_rows[i].chk;
			tbl_send = dir_rows[i].send;
			tbl_cs = dir_rows[i].cs;
			tbl_done = dir_rows[i].done;
			tbl_st = dir_rows[i].st;
			drive_xfer(dir_rows[i].op, dir_rows[i].sec, dir_rows[i].cnt, dir_rows[i].cb,
				dir_rows[i].wd);
		end
		tbl_chk = 1'b0;

		flaw_mode = 0;
		run_random(500);
		drain();

		// hold off until the engine has answered everything, then go to the maxima
		set_limits(24'hFFFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 8'd255, 8'd255);
		snd_pct = 46;
		rcv_pct = 19;
		flaw_mode = 1;
		run_random(600);
		drain();

		set_limits(24'd1, 16'd1, 8'd1, 16'd1, 8'd1, 8'd10);
		snd_pct = 0;
		rcv_pct = 0;
		flaw_mode = 2;
		run_random(600);
		drain();
		set_limits(24'd4, 16'd8, 8'd3, 16'd5, 8'd3, 8'd12);
		run_random(100);
		drain();

		if (errors == 0) $display("sd_card_spi_host_engine_unit regression: pass");
		else $display("sd_card_spi_host_engine_unit regression: fail");
		$finish;
	end

	initial begin
		#50000000;
		$display("sd_card_spi_host_engine_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
